FILE: rtl/bbl_pkg.sv
package bbl_pkg;

   localparam logic [17:0] MEM_SPAN = 18'(65536);
   localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

   // parse phases
   localparam logic [3:0] PH_START   = 4'd0;
   localparam logic [3:0] PH_TYPE    = 4'd1;
   localparam logic [3:0] PH_ADDR_LO = 4'd2;
   localparam logic [3:0] PH_ADDR_HI = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_DATA    = 4'd6;
   localparam logic [3:0] PH_RUN_LO  = 4'd7;
   localparam logic [3:0] PH_RUN_HI  = 4'd8;
   localparam logic [3:0] PH_DONE    = 4'd9;
   localparam logic [3:0] PH_RAW     = 4'd10;
   localparam logic [3:0] PH_FAILED  = 4'd11;

   // record types
   localparam logic [7:0] REC_BLOCK = 8'd1;
   localparam logic [7:0] REC_RUN   = 8'd2;

   // result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_FAILED = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_TRUNC_HDR  = 3'd1;
   localparam logic [2:0] ERR_TRUNC_DATA = 3'd2;
   localparam logic [2:0] ERR_PAST_SPACE = 3'd3;
   localparam logic [2:0] ERR_BAD_TYPE   = 3'd4;

   // register indexes
   localparam logic [2:0] REG_HEADER_MODE = 3'd0;
   localparam logic [2:0] REG_LOAD_BASE   = 3'd1;
   localparam logic [2:0] REG_RUN_ENABLE  = 3'd2;
   localparam logic [2:0] REG_RUN_START   = 3'd3;
   localparam logic [2:0] REG_ALL_RAM     = 3'd4;

   typedef struct packed {
      logic        header_mode;
      logic [15:0] load_base;
      logic        run_enable;
      logic [15:0] run_start;
      logic        all_ram_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] write_address;
      logic [7:0]  write_byte;
      logic        write_all_ram;
      logic        run_valid;
      logic [15:0] run_address_out;
      logic [2:0]  error_code;
      logic [19:0] loaded_count;
      logic        final_result;
   } result_type;

   // up to two words handed from the parser to the queue at once
   typedef struct packed {
      logic [1:0] count;
      result_type word0;
      result_type word1;
   } push_type;

endpackage

FILE: rtl/bbl_req_if.sv
interface bbl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       byte_present;
   logic       end_of_file;

   modport source (output valid, byte_value, byte_present, end_of_file, input ready);
   modport sink (input valid, byte_value, byte_present, end_of_file, output ready);
endinterface

FILE: rtl/bbl_rsp_if.sv
interface bbl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] write_address;
   logic [7:0]  write_byte;
   logic        write_all_ram;
   logic        run_valid;
   logic [15:0] run_address_out;
   logic [2:0]  error_code;
   logic [19:0] loaded_count;
   logic        final_result;

   modport source (output valid, result_kind, write_address, write_byte, write_all_ram,
                   run_valid, run_address_out, error_code, loaded_count, final_result,
                   input ready);
   modport sink (input valid, result_kind, write_address, write_byte, write_all_ram,
                 run_valid, run_address_out, error_code, loaded_count, final_result,
                 output ready);
endinterface

FILE: rtl/bbl_csr_if.sv
interface bbl_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/binary_block_loader_parser.sv
// Loads a memory image one byte word at a time and turns it into memory writes, in raw mode at
// consecutive addresses from load_base, in header mode by parsing block and run records. An
// input word is taken every cycle while the queue has room; the parser settles each word
// combinationally and drops up to two results (a write or failure for the byte, plus the
// outcome for an end marker) into a four-word result queue. The response port drains one word
// per cycle while rsp ready is high; req ready drops while fewer than two queue words are free.
// Writes go out as bytes arrive; a failure later in the file does not recall them.
module binary_block_loader_parser (
   input  logic  clock,
   input  logic  reset,
   bbl_req_if.sink   req_chan,
   bbl_rsp_if.source rsp_chan,
   bbl_csr_if.sink   csr_chan
);

   bbl_pkg::cfg_type    cfg_ff, cfg_in;
   bbl_pkg::push_type   push;
   bbl_pkg::result_type head;
   logic                room;
   logic                accept;
   logic                head_valid;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bbl_pkg::REG_HEADER_MODE: cfg_in.header_mode = csr_chan.data[0];
            bbl_pkg::REG_LOAD_BASE:   cfg_in.load_base = csr_chan.data;
            bbl_pkg::REG_RUN_ENABLE:  cfg_in.run_enable = csr_chan.data[0];
            bbl_pkg::REG_RUN_START:   cfg_in.run_start = csr_chan.data;
            bbl_pkg::REG_ALL_RAM:     cfg_in.all_ram_mode = csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mode <= 1'b1;
         cfg_ff.load_base <= '0;
         cfg_ff.run_enable <= 1'b0;
         cfg_ff.run_start <= '0;
         cfg_ff.all_ram_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = room;
   assign accept = req_chan.valid && room;

   bbl_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_value   (req_chan.byte_value),
      .byte_present (req_chan.byte_present),
      .end_of_file  (req_chan.end_of_file),
      .cfg          (cfg_ff),
      .push         (push)
   );

   bbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (head_valid),
      .out_ready (rsp_chan.ready),
      .out_word  (head)
   );

   assign rsp_chan.valid = head_valid;
   assign rsp_chan.result_kind = head.result_kind;
   assign rsp_chan.write_address = head.write_address;
   assign rsp_chan.write_byte = head.write_byte;
   assign rsp_chan.write_all_ram = head.write_all_ram;
   assign rsp_chan.run_valid = head.run_valid;
   assign rsp_chan.run_address_out = head.run_address_out;
   assign rsp_chan.error_code = head.error_code;
   assign rsp_chan.loaded_count = head.loaded_count;
   assign rsp_chan.final_result = head.final_result;

   // a word with neither byte nor end marker leaves no result
   a_empty_word_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.byte_present && !req_chan.end_of_file) |-> (push.count == 2'd0))
      else $error("empty word produced a result");

   // of two results from one word only the second is marked last
   a_final_marking: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.word1.final_result && !push.word0.final_result))
      else $error("final marking wrong on double result");

   // nothing is pushed unless a word was taken
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (push.count == 2'd0))
      else $error("result pushed without an input word");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

FILE: rtl/bbl_parse.sv
module bbl_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       byte_value,
   input  logic             byte_present,
   input  logic             end_of_file,
   input  bbl_pkg::cfg_type cfg,
   output bbl_pkg::push_type push
);

   logic [3:0]  phase_ff, phase_in;
   logic [16:0] addr_ff, addr_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  lo_ff, lo_in;
   logic        rflag_ff, rflag_in;
   logic [15:0] rval_ff, rval_in;
   logic [19:0] total_ff, total_in;

   always_comb begin
      logic [3:0]          ph;
      logic [16:0]         addr;
      logic [15:0]         rem;
      logic [7:0]          lo;
      logic                rflag;
      logic [15:0]         rval;
      logic [19:0]         total;
      logic [17:0]         sum;
      logic                do_fail;
      logic                do_write;
      logic [2:0]          code;
      logic                r0_v;
      logic                e_v;
      bbl_pkg::result_type r0;
      bbl_pkg::result_type e;

      ph = phase_ff;
      addr = addr_ff;
      rem = rem_ff;
      lo = lo_ff;
      rflag = rflag_ff;
      rval = rval_ff;
      total = total_ff;
      sum = '0;
      do_fail = 1'b0;
      do_write = 1'b0;
      code = bbl_pkg::ERR_NONE;
      r0_v = 1'b0;
      e_v = 1'b0;
      r0 = '0;
      e = '0;

      if (accept && byte_present) begin
         if (ph == bbl_pkg::PH_START) begin
            if (cfg.header_mode) begin
               ph = bbl_pkg::PH_TYPE;
            end else begin
               ph = bbl_pkg::PH_RAW;
               addr = {1'b0, cfg.load_base};
            end
         end
         unique case (ph)
            bbl_pkg::PH_TYPE: begin
               if (byte_value == bbl_pkg::REC_BLOCK) begin
                  ph = bbl_pkg::PH_ADDR_LO;
               end else if (byte_value == bbl_pkg::REC_RUN) begin
                  ph = bbl_pkg::PH_RUN_LO;
               end else begin
                  do_fail = 1'b1;
                  code = bbl_pkg::ERR_BAD_TYPE;
               end
            end
            bbl_pkg::PH_ADDR_LO: begin
               lo = byte_value;
               ph = bbl_pkg::PH_ADDR_HI;
            end
            bbl_pkg::PH_ADDR_HI: begin
               addr = {1'b0, byte_value, lo};
               ph = bbl_pkg::PH_LEN_LO;
            end
            bbl_pkg::PH_LEN_LO: begin
               lo = byte_value;
               ph = bbl_pkg::PH_LEN_HI;
            end
            bbl_pkg::PH_LEN_HI: begin
               rem = {byte_value, lo};
               sum = {1'b0, addr} + {2'b00, rem};
               if (sum > bbl_pkg::MEM_SPAN) begin
                  do_fail = 1'b1;
                  code = bbl_pkg::ERR_PAST_SPACE;
               end else if (rem != '0) begin
                  ph = bbl_pkg::PH_DATA;
               end else begin
                  ph = bbl_pkg::PH_TYPE;
               end
            end
            bbl_pkg::PH_DATA: begin
               rem = rem - 16'd1;
               if (rem == '0) begin
                  ph = bbl_pkg::PH_TYPE;
               end
               do_write = 1'b1;
            end
            bbl_pkg::PH_RUN_LO: begin
               lo = byte_value;
               ph = bbl_pkg::PH_RUN_HI;
            end
            bbl_pkg::PH_RUN_HI: begin
               rval = {byte_value, lo};
               rflag = 1'b1;
               ph = bbl_pkg::PH_DONE;
            end
            bbl_pkg::PH_RAW: begin
               if ({1'b0, addr} >= bbl_pkg::MEM_SPAN) begin
                  do_fail = 1'b1;
                  code = bbl_pkg::ERR_PAST_SPACE;
               end else begin
                  do_write = 1'b1;
               end
            end
            default: begin
               // done or failed: the byte is ignored
            end
         endcase

         if (do_fail) begin
            ph = bbl_pkg::PH_FAILED;
            r0_v = 1'b1;
            r0.result_kind = bbl_pkg::KIND_FAILED;
            r0.error_code = code;
            r0.loaded_count = total;
         end
         if (do_write) begin
            if (total < bbl_pkg::COUNT_MAX) begin
               total = total + 20'd1;
            end
            r0_v = 1'b1;
            r0.result_kind = bbl_pkg::KIND_WRITE;
            r0.write_address = addr[15:0];
            r0.write_byte = byte_value;
            r0.write_all_ram = cfg.all_ram_mode;
            r0.loaded_count = total;
            addr = addr + 17'd1;
         end
      end

      if (accept && end_of_file) begin
         e.loaded_count = total;
         unique case (ph)
            bbl_pkg::PH_START: begin
               e_v = 1'b1;
               e.result_kind = bbl_pkg::KIND_DONE;
               if (cfg.header_mode) begin
                  e.run_valid = rflag;
                  e.run_address_out = rflag ? rval : '0;
               end else begin
                  e.run_valid = cfg.run_enable;
                  e.run_address_out = cfg.run_enable ? cfg.run_start : '0;
               end
            end
            bbl_pkg::PH_RAW: begin
               e_v = 1'b1;
               e.result_kind = bbl_pkg::KIND_DONE;
               e.run_valid = cfg.run_enable;
               e.run_address_out = cfg.run_enable ? cfg.run_start : '0;
            end
            bbl_pkg::PH_TYPE, bbl_pkg::PH_DONE: begin
               e_v = 1'b1;
               e.result_kind = bbl_pkg::KIND_DONE;
               e.run_valid = rflag;
               e.run_address_out = rflag ? rval : '0;
            end
            bbl_pkg::PH_ADDR_LO, bbl_pkg::PH_ADDR_HI, bbl_pkg::PH_LEN_LO,
            bbl_pkg::PH_LEN_HI, bbl_pkg::PH_RUN_LO, bbl_pkg::PH_RUN_HI: begin
               e_v = 1'b1;
               e.result_kind = bbl_pkg::KIND_FAILED;
               e.error_code = bbl_pkg::ERR_TRUNC_HDR;
            end
            bbl_pkg::PH_DATA: begin
               e_v = 1'b1;
               e.result_kind = bbl_pkg::KIND_FAILED;
               e.error_code = bbl_pkg::ERR_TRUNC_DATA;
            end
            default: begin
               // after a failure the end rearms silently
            end
         endcase
         ph = bbl_pkg::PH_START;
         addr = '0;
         rem = '0;
         lo = '0;
         rflag = 1'b0;
         rval = '0;
         total = '0;
      end

      e.final_result = 1'b1;
      r0.final_result = !e_v;

      phase_in = ph;
      addr_in = addr;
      rem_in = rem;
      lo_in = lo;
      rflag_in = rflag;
      rval_in = rval;
      total_in = total;

      push.count = {1'b0, r0_v} + {1'b0, e_v};
      if (r0_v) begin
         push.word0 = r0;
         push.word1 = e;
      end else begin
         push.word0 = e;
         push.word1 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bbl_pkg::PH_START;
         addr_ff <= '0;
         rem_ff <= '0;
         lo_ff <= '0;
         rflag_ff <= 1'b0;
         rval_ff <= '0;
         total_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         addr_ff <= addr_in;
         rem_ff <= rem_in;
         lo_ff <= lo_in;
         rflag_ff <= rflag_in;
         rval_ff <= rval_in;
         total_ff <= total_in;
      end
   end

endmodule

FILE: rtl/bbl_queue.sv
module bbl_queue (
   input  logic                clock,
   input  logic                reset,
   input  bbl_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output bbl_pkg::result_type out_word
);

   bbl_pkg::result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // two free words needed since one item can leave two results
   assign room = (count_ff <= 3'd2);
   assign out_valid = (count_ff != '0);
   assign out_word = entry_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
